// File: hdl/gte_pkg.sv
// Shared constants, codes and types of the graph traversal engine.
// No dependencies.
package gte_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_ENTRIES  = 512;

    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ENT_W  = $clog2(MAX_ENTRIES);
    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
    localparam int LVL_W  = 2;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_ENTRIES);

    localparam logic [2:0] MODE_ADD_VERTEX = 3'd0;
    localparam logic [2:0] MODE_ADD_EDGE   = 3'd1;
    localparam logic [2:0] MODE_BFS        = 3'd2;
    localparam logic [2:0] MODE_DFS        = 3'd3;
    localparam logic [2:0] MODE_SUGGEST    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_VFULL    = 3'd1;
    localparam logic [2:0] ST_BAD_ID   = 3'd2;
    localparam logic [2:0] ST_EFULL    = 3'd3;
    localparam logic [2:0] ST_NO_SUGG  = 3'd4;

    typedef struct packed {
        logic             push;
        logic             fin;
        logic [VID_W-1:0] vertex;
        logic [2:0]       status;
    } t_emit_req;
endpackage

// File: hdl/graph_traversal_engine_unit.sv
// Top level of the graph traversal engine: sequencer plus result staging.
// Depends on gte_pkg, gte_engine, gte_emit.
//
// Usage: a command (i_mode, i_first_id, i_second_id) is taken at a rising
// edge with start high and busy low. Modes: add vertex, add edge,
// breadth-first, depth-first, suggest (vertices at distance two).
// Results appear on o_vertex_out/o_last/o_status for one cycle each, marked
// by o_valid; the final result of a command has o_last set. Unused modes
// give no result. The receiver cannot stall: every result is taken.
// Add vertex gives its result in the cycle after acceptance; add edge
// passes S_EDGE0 before a rejection, then S_EA and S_EB when stored. A
// breadth-first walk steps each vertex through S_BDEQ, S_BCUR, S_BHEAD and
// S_BEDGE and each entry through S_BNB; a depth-first walk uses S_DTOP,
// S_DTOPW, S_DSCAN, S_DENT and S_DPUSH (every list read goes through a
// synchronous memory), and a suggest query scans the ids through S_SRD and
// S_SCHK. Query results trail by one; one is held back to mark the last.
// Reset (synchronous, active low) empties the graph: no vertices, no edges,
// all adjacency lists null. No clearing pass is needed.
module graph_traversal_engine_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_mode,
    input  logic [gte_pkg::VID_W-1:0] i_first_id,
    input  logic [gte_pkg::VID_W-1:0] i_second_id,
    output logic                      o_valid,
    output logic [gte_pkg::VID_W-1:0] o_vertex_out,
    output logic                      o_last,
    output logic [2:0]                o_status
);
    import gte_pkg::*;

    t_emit_req req;

    gte_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (start),
        .i_mode      (i_mode),
        .i_first_id  (i_first_id),
        .i_second_id (i_second_id),
        .o_busy      (busy),
        .o_req       (req)
    );

    gte_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_valid      (o_valid),
        .o_vertex_out (o_vertex_out),
        .o_last       (o_last),
        .o_status     (o_status)
    );
endmodule

// File: hdl/gte_emit.sv
// Result staging: holds one pending vertex so the final one can carry last.
// Depends on gte_pkg.
module gte_emit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gte_pkg::t_emit_req       i_req,
    output logic                     o_valid,
    output logic [gte_pkg::VID_W-1:0] o_vertex_out,
    output logic                     o_last,
    output logic [2:0]               o_status
);
    import gte_pkg::*;

    logic             r_pend;
    logic [VID_W-1:0] r_pend_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_req.push) begin
                o_valid      <= r_pend;
                o_vertex_out <= r_pend_v;
                o_last       <= 1'b0;
                o_status     <= ST_OK;
                r_pend       <= 1'b1;
                r_pend_v     <= i_req.vertex;
            end else if (i_req.fin) begin
                o_valid <= 1'b1;
                o_last  <= 1'b1;
                r_pend  <= 1'b0;
                if (r_pend) begin
                    o_vertex_out <= r_pend_v;
                    o_status     <= ST_OK;
                end else begin
                    o_vertex_out <= i_req.vertex;
                    o_status     <= i_req.status;
                end
            end
        end
    end
endmodule

// File: hdl/gte_engine.sv
// Command sequencer with the graph memories (heads, entries, levels, queue, stack).
// Depends on gte_pkg.
module gte_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [2:0]                i_mode,
    input  logic [gte_pkg::VID_W-1:0] i_first_id,
    input  logic [gte_pkg::VID_W-1:0] i_second_id,
    output logic                      o_busy,
    output gte_pkg::t_emit_req        o_req
);
    import gte_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_EA    = 5'd1,  S_EB    = 5'd2,
                           S_QCHK  = 5'd3,  S_BINIT = 5'd4,  S_BDEQ  = 5'd5,
                           S_BCUR  = 5'd6,  S_BHEAD = 5'd7,  S_BEDGE = 5'd8,
                           S_BNB   = 5'd9,  S_SRD   = 5'd10, S_SCHK  = 5'd11,
                           S_DINIT = 5'd12, S_DROOT = 5'd13, S_DTOP  = 5'd14,
                           S_DTOPW = 5'd15, S_DSCAN = 5'd16, S_DENT  = 5'd17,
                           S_DPUSH = 5'd18, S_EDGE0 = 5'd19;

    logic [4:0]        r_state, n_state;
    logic [2:0]        r_mode;
    logic [VID_W-1:0]  r_a, r_b, r_cur, n_cur;
    logic [CNT_W-1:0]  r_vcnt, n_vcnt, r_front, n_front, r_rear, n_rear;
    logic [CNT_W-1:0]  r_depth, n_depth, r_idx, n_idx;
    logic [LINK_W-1:0] r_ecnt, n_ecnt, r_e, n_e;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [MAX_VERTICES-1:0] r_vis, r_hvld;

    logic [LINK_W-1:0] head_mem [MAX_VERTICES];
    logic [LINK_W+VID_W-1:0] ent_mem [MAX_ENTRIES];
    logic [LVL_W-1:0]  lvl_mem [MAX_VERTICES];
    logic [VID_W-1:0]  q_mem   [MAX_VERTICES];
    logic [LINK_W-1:0] stk_mem [MAX_VERTICES];

    logic [VID_W-1:0]  head_ra, r_head_ra, head_wa, lvl_ra, lvl_wa, q_ra, q_wa;
    logic [VID_W-1:0]  stk_ra, stk_wa, vis_sa;
    logic [ENT_W-1:0]  ent_ra, ent_wa;
    logic              head_we, ent_we, lvl_we, q_we, stk_we, vis_set, vis_clr;
    logic [LINK_W-1:0] head_wd, head_rd, stk_wd, stk_rd, head_v;
    logic [LINK_W+VID_W-1:0] ent_wd, ent_rd;
    logic [LVL_W-1:0]  lvl_wd, lvl_rd;
    logic [VID_W-1:0]  q_wd, q_rd, ent_tgt;
    logic [LINK_W-1:0] ent_nxt;
    t_emit_req         req;

    assign head_v  = r_hvld[r_head_ra] ? head_rd : NO_LINK;
    assign ent_tgt = ent_rd[VID_W-1:0];
    assign ent_nxt = ent_rd[LINK_W+VID_W-1:VID_W];
    assign o_busy  = (r_state != S_IDLE);
    assign o_req   = req;

    always_ff @(posedge i_clk) begin
        head_rd   <= head_mem[head_ra];
        r_head_ra <= head_ra;
        ent_rd    <= ent_mem[ent_ra];
        lvl_rd    <= lvl_mem[lvl_ra];
        q_rd      <= q_mem[q_ra];
        stk_rd    <= stk_mem[stk_ra];
        if (head_we) head_mem[head_wa] <= head_wd;
        if (ent_we)  ent_mem[ent_wa]   <= ent_wd;
        if (lvl_we)  lvl_mem[lvl_wa]   <= lvl_wd;
        if (q_we)    q_mem[q_wa]       <= q_wd;
        if (stk_we)  stk_mem[stk_wa]   <= stk_wd;
    end

    always_comb begin
        n_state = r_state;  n_cur = r_cur;   n_vcnt = r_vcnt;  n_front = r_front;
        n_rear = r_rear;    n_depth = r_depth; n_idx = r_idx;  n_ecnt = r_ecnt;
        n_e = r_e;          n_lvl = r_lvl;
        head_ra = r_a;  head_we = 1'b0; head_wa = r_a; head_wd = r_ecnt;
        ent_ra = r_e[ENT_W-1:0]; ent_we = 1'b0; ent_wa = r_ecnt[ENT_W-1:0];
        ent_wd = {head_v, r_b};
        lvl_ra = r_cur; lvl_we = 1'b0; lvl_wa = r_a; lvl_wd = '0;
        q_ra = r_front[VID_W-1:0]; q_we = 1'b0; q_wa = r_rear[VID_W-1:0]; q_wd = r_a;
        stk_ra = VID_W'(r_depth - 1'b1); stk_we = 1'b0; stk_wa = '0; stk_wd = head_v;
        vis_set = 1'b0; vis_clr = 1'b0; vis_sa = r_a;
        req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    unique case (i_mode)
                        MODE_ADD_VERTEX: begin
                            req.fin = 1'b1;
                            if (r_vcnt >= CNT_W'(MAX_VERTICES)) begin
                                req.status = ST_VFULL;
                            end else begin
                                req.vertex = r_vcnt[VID_W-1:0];
                                n_vcnt     = r_vcnt + 1'b1;
                            end
                        end
                        MODE_ADD_EDGE: n_state = S_EDGE0;
                        MODE_BFS, MODE_DFS, MODE_SUGGEST: n_state = S_QCHK;
                        default: ;
                    endcase
                end
            end
            S_EDGE0: begin
                if (CNT_W'(r_a) >= r_vcnt || CNT_W'(r_b) >= r_vcnt) begin
                    req.fin = 1'b1; req.status = ST_BAD_ID; n_state = S_IDLE;
                end else if ({1'b0, r_ecnt} + 2'd2 > (LINK_W+1)'(MAX_ENTRIES)) begin
                    req.fin = 1'b1; req.status = ST_EFULL; n_state = S_IDLE;
                end else begin
                    n_state = S_EA;
                end
            end
            S_EA: begin
                ent_we = 1'b1; ent_wd = {head_v, r_b};
                head_we = 1'b1; head_wa = r_a; head_wd = r_ecnt;
                head_ra = r_b;
                n_state = S_EB;
            end
            S_EB: begin
                ent_we = 1'b1; ent_wa = ENT_W'(r_ecnt + 1'b1);
                // self edge: the head was just rewritten in the previous cycle
                ent_wd = {(r_a == r_b) ? r_ecnt : head_v, r_a};
                head_we = 1'b1; head_wa = r_b; head_wd = r_ecnt + 1'b1;
                n_ecnt = r_ecnt + 2'd2;
                req.fin = 1'b1;
                n_state = S_IDLE;
            end
            S_QCHK: begin
                vis_clr = 1'b1;
                if (CNT_W'(r_a) >= r_vcnt) begin
                    req.fin = 1'b1; req.status = ST_BAD_ID; n_state = S_IDLE;
                end else if (r_mode == MODE_DFS) begin
                    n_state = S_DINIT;
                end else begin
                    n_state = S_BINIT;
                end
            end
            S_BINIT: begin
                vis_set = 1'b1; lvl_we = 1'b1; q_we = 1'b1; q_wa = '0;
                n_rear = CNT_W'(1); n_front = '0;
                req.push = (r_mode == MODE_BFS); req.vertex = r_a;
                n_state = S_BDEQ;
            end
            S_BDEQ: begin
                if (r_front == r_rear) begin
                    if (r_mode == MODE_BFS) begin
                        req.fin = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_idx = '0; n_state = S_SRD;
                    end
                end else begin
                    n_front = r_front + 1'b1;
                    n_state = S_BCUR;
                end
            end
            S_BCUR: begin
                n_cur = q_rd; head_ra = q_rd; lvl_ra = q_rd;
                n_state = S_BHEAD;
            end
            S_BHEAD: begin
                n_e = head_v; n_lvl = lvl_rd;
                n_state = S_BEDGE;
            end
            S_BEDGE: begin
                n_state = (r_e < r_ecnt) ? S_BNB : S_BDEQ;
            end
            S_BNB: begin
                if (!r_vis[ent_tgt] && r_rear < CNT_W'(MAX_VERTICES)) begin
                    vis_set = 1'b1; vis_sa = ent_tgt;
                    lvl_we = 1'b1; lvl_wa = ent_tgt;
                    lvl_wd = (r_lvl == 2'd3) ? 2'd3 : r_lvl + 1'b1;
                    q_we = 1'b1; q_wd = ent_tgt;
                    n_rear = r_rear + 1'b1;
                    req.push = (r_mode == MODE_BFS); req.vertex = ent_tgt;
                end
                n_e = ent_nxt;
                n_state = S_BEDGE;
            end
            S_SRD: begin
                lvl_ra = r_idx[VID_W-1:0];
                if (r_idx >= r_vcnt) begin
                    req.fin = 1'b1; req.status = ST_NO_SUGG; n_state = S_IDLE;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (r_vis[r_idx[VID_W-1:0]] && lvl_rd == 2'd2) begin
                    req.push = 1'b1; req.vertex = r_idx[VID_W-1:0];
                end
                n_idx = r_idx + 1'b1;
                n_state = S_SRD;
            end
            S_DINIT: begin
                vis_set = 1'b1; req.push = 1'b1; req.vertex = r_a;
                n_state = S_DROOT;
            end
            S_DROOT: begin
                stk_we = 1'b1; stk_wa = '0; stk_wd = head_v;
                n_depth = CNT_W'(1);
                n_state = S_DTOP;
            end
            S_DTOP: begin
                if (r_depth == '0) begin
                    req.fin = 1'b1; n_state = S_IDLE;
                end else begin
                    n_state = S_DTOPW;
                end
            end
            S_DTOPW: begin
                n_e = stk_rd; n_state = S_DSCAN;
            end
            S_DSCAN: begin
                if (r_e < r_ecnt) begin
                    n_state = S_DENT;
                end else begin
                    n_depth = r_depth - 1'b1; n_state = S_DTOP;
                end
            end
            S_DENT: begin
                if (r_vis[ent_tgt]) begin
                    n_e = ent_nxt; n_state = S_DSCAN;
                end else if (r_depth >= CNT_W'(MAX_VERTICES)) begin
                    n_depth = r_depth - 1'b1; n_state = S_DTOP;
                end else begin
                    stk_we = 1'b1; stk_wa = VID_W'(r_depth - 1'b1); stk_wd = ent_nxt;
                    vis_set = 1'b1; vis_sa = ent_tgt;
                    req.push = 1'b1; req.vertex = ent_tgt;
                    head_ra = ent_tgt;
                    n_state = S_DPUSH;
                end
            end
            S_DPUSH: begin
                stk_we = 1'b1; stk_wa = r_depth[VID_W-1:0]; stk_wd = head_v;
                n_depth = r_depth + 1'b1;
                n_state = S_DTOP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_ecnt  <= '0;
            r_hvld  <= '0;
            r_vis   <= '0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_ecnt  <= n_ecnt;
            if (head_we) r_hvld[head_wa] <= 1'b1;
            if (vis_clr) r_vis <= '0;
            else if (vis_set) r_vis[vis_sa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_go) begin
            r_mode <= i_mode;
            r_a    <= i_first_id;
            r_b    <= i_second_id;
        end
        r_cur   <= n_cur;
        r_front <= n_front;
        r_rear  <= n_rear;
        r_depth <= n_depth;
        r_idx   <= n_idx;
        r_e     <= n_e;
        r_lvl   <= n_lvl;
    end

    a_push_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.push && req.fin)) else $error("push and finish together");
    a_idle_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.fin |=> (r_state == S_IDLE)) else $error("finish without return to idle");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= LINK_W'(MAX_ENTRIES)) else $error("edge count overflow");
    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CNT_W'(MAX_VERTICES)) else $error("vertex count overflow");
endmodule

// File: verif/graph_traversal_engine_unit_test.sv
// Self-checking testbench for graph_traversal_engine_unit: directed and random commands
// checked against an internal graph predictor. Depends on gte_pkg and the RTL top level.
module graph_traversal_engine_unit_test;
    import gte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit         drain;
        logic [2:0] mode;
        logic [5:0] a;
        logic [5:0] b;
    } t_cmd;

    typedef struct {
        logic [5:0] vertex;
        logic       last;
        logic [2:0] status;
    } t_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] i_mode = 3'd0;
    logic [5:0] i_first_id = 6'd0;
    logic [5:0] i_second_id = 6'd0;
    wire        busy, o_valid, o_last;
    wire  [5:0] o_vertex_out;
    wire  [2:0] o_status;

    graph_traversal_engine_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_first_id(i_first_id), .i_second_id(i_second_id),
        .o_valid(o_valid), .o_vertex_out(o_vertex_out), .o_last(o_last),
        .o_status(o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   errors = 0;
    int   cycle = 0;

    // graph model
    int         g_vcount = 0;
    int         g_ecount = 0;
    logic [9:0] g_head[64];
    logic [9:0] g_next[512];
    logic [5:0] g_target[512];
    bit         g_seen[64];
    logic [1:0] g_level[64];
    logic [5:0] g_order[64];
    logic [9:0] g_cursor[64];
    int         emitted;

    initial begin
        for (int i = 0; i < 64; i++) g_head[i] = 10'(MAX_ENTRIES);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle, msg);
        errors++;
    endtask

    function automatic void push_result(logic [5:0] v, logic l, logic [2:0] s);
        t_res r;
        if (emitted >= 64) return;
        r.vertex = v; r.last = l; r.status = s;
        expected_results.push_back(r);
        emitted++;
    endfunction

    function automatic void mark_final();
        if (emitted > 0) expected_results[expected_results.size()-1].last = 1'b1;
    endfunction

    function automatic bit link_ok(logic [9:0] e);
        return int'(e) < g_ecount;
    endfunction

    function automatic int breadth_walk(int s);
        int front = 0, rear = 0;
        logic [9:0] e;
        int cur, nb;
        for (int i = 0; i < 64; i++) begin g_seen[i] = 0; g_level[i] = 0; end
        g_seen[s] = 1;
        g_order[rear++] = 6'(s);
        while (front < rear) begin
            cur = g_order[front++];
            e = g_head[cur];
            while (link_ok(e)) begin
                nb = g_target[e];
                if (!g_seen[nb] && rear < 64) begin
                    g_seen[nb] = 1;
                    g_level[nb] = (g_level[cur] < 3) ? g_level[cur] + 2'd1 : 2'd3;
                    g_order[rear++] = 6'(nb);
                end
                e = g_next[e];
            end
        end
        return rear;
    endfunction

    function automatic void predict_cmd(t_cmd c);
        int a, b, cnt, depth, nb;
        logic [9:0] e;
        a = c.a; b = c.b;
        emitted = 0;
        case (c.mode)
            MODE_ADD_VERTEX: begin
                if (g_vcount >= 64) push_result(0, 1, ST_VFULL);
                else begin
                    push_result(6'(g_vcount), 1, ST_OK);
                    g_vcount++;
                end
            end
            MODE_ADD_EDGE: begin
                if (a >= g_vcount || b >= g_vcount) push_result(0, 1, ST_BAD_ID);
                else if (g_ecount + 2 > MAX_ENTRIES) push_result(0, 1, ST_EFULL);
                else begin
                    g_target[g_ecount] = 6'(b); g_next[g_ecount] = g_head[a];
                    g_head[a] = 10'(g_ecount); g_ecount++;
                    g_target[g_ecount] = 6'(a); g_next[g_ecount] = g_head[b];
                    g_head[b] = 10'(g_ecount); g_ecount++;
                    push_result(0, 1, ST_OK);
                end
            end
            MODE_BFS, MODE_DFS, MODE_SUGGEST: begin
                if (a >= g_vcount) push_result(0, 1, ST_BAD_ID);
                else if (c.mode == MODE_BFS) begin
                    cnt = breadth_walk(a);
                    for (int i = 0; i < cnt; i++) push_result(g_order[i], 0, ST_OK);
                    mark_final();
                end else if (c.mode == MODE_DFS) begin
                    for (int i = 0; i < 64; i++) begin g_seen[i] = 0; g_level[i] = 0; end
                    g_seen[a] = 1;
                    g_cursor[0] = g_head[a];
                    depth = 1;
                    push_result(6'(a), 0, ST_OK);
                    while (depth > 0) begin
                        e = g_cursor[depth-1];
                        while (link_ok(e) && g_seen[g_target[e]]) e = g_next[e];
                        if (!link_ok(e) || depth >= 64) depth--;
                        else begin
                            nb = g_target[e];
                            g_cursor[depth-1] = g_next[e];
                            g_seen[nb] = 1;
                            g_cursor[depth] = g_head[nb];
                            depth++;
                            push_result(6'(nb), 0, ST_OK);
                        end
                    end
                    mark_final();
                end else begin
                    void'(breadth_walk(a));
                    for (int i = 0; i < g_vcount; i++)
                        if (g_seen[i] && g_level[i] == 2'd2) push_result(6'(i), 0, ST_OK);
                    if (emitted == 0) push_result(0, 1, ST_NO_SUGG);
                    else mark_final();
                end
            end
            default: ;  // unused modes: no result
        endcase
    endfunction

    // driver
    t_cmd cur_cmd;
    int   gap_left = 0;
    int   quiet = 0;
    always @(posedge i_clk) begin
        logic next_start;
        t_cmd nc;
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                predict_cmd(cur_cmd);
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_cmds.size() > 0) begin
                    nc = pending_cmds[0];
                    if (nc.drain) begin
                        // hold off until the engine has gone quiet
                        if (expected_results.size() == 0 && !start) begin
                            if (quiet >= 40) begin
                                void'(pending_cmds.pop_front());
                                quiet <= 0;
                            end else quiet <= quiet + 1;
                        end else quiet <= 0;
                    end else begin
                        void'(pending_cmds.pop_front());
                        cur_cmd = nc;
                        i_mode <= nc.mode;
                        i_first_id <= nc.a;
                        i_second_id <= nc.b;
                        next_start = 1'b1;
                        case ($urandom_range(0, 19))
                            0:          gap_left <= $urandom_range(20, 80);
                            1, 2, 3:    gap_left <= $urandom_range(1, 4);
                            default:    gap_left <= 0;
                        endcase
                    end
                end
            end
            start <= next_start;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result v=%0d l=%0b s=%0d",
                                o_vertex_out, o_last, o_status));
            end else begin
                r = expected_results.pop_front();
                if (o_vertex_out !== r.vertex)
                    report_mismatch($sformatf("vertex %0d exp %0d", o_vertex_out, r.vertex));
                if (o_last !== r.last)
                    report_mismatch($sformatf("last %0b exp %0b", o_last, r.last));
                if (o_status !== r.status)
                    report_mismatch($sformatf("status %0d exp %0d", o_status, r.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle >= 3000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    int gen_v = 0;
    int gen_e = 0;

    task automatic add_cmd(input logic [2:0] m, input logic [5:0] a, input logic [5:0] b);
        t_cmd c;
        c.drain = 0; c.mode = m; c.a = a; c.b = b;
        if (m == MODE_ADD_VERTEX && gen_v < 64) gen_v++;
        if (m == MODE_ADD_EDGE && a < gen_v && b < gen_v && gen_e + 2 <= MAX_ENTRIES)
            gen_e += 2;
        pending_cmds.push_back(c);
    endtask

    task automatic add_drain();
        t_cmd c;
        c.drain = 1; c.mode = 0; c.a = 0; c.b = 0;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [5:0] pick_id();
        if (gen_v > 0 && $urandom_range(0, 99) < 85) return 6'($urandom_range(0, gen_v - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin
        int r;
        logic [2:0] m;
        // empty graph, unused modes
        add_cmd(MODE_BFS, 0, 0);
        add_cmd(MODE_ADD_EDGE, 0, 0);
        add_cmd(MODE_SUGGEST, 0, 0);
        add_cmd(3'd5, 6'd63, 6'd63);
        add_cmd(3'd6, 0, 0);
        add_cmd(3'd7, 6'd21, 6'd42);
        for (int i = 0; i < 4; i++) add_cmd(MODE_ADD_VERTEX, 0, 0);
        add_cmd(MODE_ADD_EDGE, 0, 1);
        add_cmd(MODE_ADD_EDGE, 1, 2);
        add_cmd(MODE_ADD_EDGE, 2, 3);
        add_cmd(MODE_ADD_EDGE, 3, 3);      // self edge
        add_cmd(MODE_ADD_EDGE, 0, 6'd63);  // bad destination
        add_cmd(MODE_ADD_EDGE, 6'd63, 0);  // bad source
        add_cmd(MODE_BFS, 0, 0);
        add_cmd(MODE_DFS, 0, 0);
        add_cmd(MODE_SUGGEST, 0, 0);
        add_cmd(MODE_SUGGEST, 3, 0);
        add_cmd(MODE_ADD_VERTEX, 0, 0);
        add_cmd(MODE_SUGGEST, 4, 0);       // isolated: none found
        add_cmd(MODE_DFS, 6'd63, 0);
        add_drain();

        for (int n = 0; n < 400; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) m = MODE_ADD_VERTEX;
            else if (r < 62) m = MODE_ADD_EDGE;
            else if (r < 75) m = MODE_BFS;
            else if (r < 87) m = MODE_DFS;
            else if (r < 97) m = MODE_SUGGEST;
            else m = 3'($urandom_range(5, 7));
            add_cmd(m, pick_id(), pick_id());
            if (n % 150 == 149) add_drain();
        end
        // fill both stores to their limits
        while (gen_v < 64) add_cmd(MODE_ADD_VERTEX, 0, 0);
        add_cmd(MODE_ADD_VERTEX, 0, 0);
        while (gen_e + 2 <= MAX_ENTRIES)
            add_cmd(MODE_ADD_EDGE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        add_cmd(MODE_ADD_EDGE, 6'd63, 6'd0);
        add_cmd(MODE_BFS, 6'd63, 0);
        add_cmd(MODE_DFS, 6'd0, 0);
        add_cmd(MODE_SUGGEST, 6'd42, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && !start && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/gte_pkg.sv
hdl/gte_emit.sv
hdl/gte_engine.sv
hdl/graph_traversal_engine_unit.sv
verif/graph_traversal_engine_unit_test.sv
